/* hw/rtl/svl_pkg.sv */
// ----------------------------------------------------------------------------
// svl_pkg
// Shared types and codes for the sorted value list: request and response
// payloads, operation and status codes, and the command to the entry row.
// ----------------------------------------------------------------------------
package svl_pkg;

  localparam int DefaultCapacity = 16;
  localparam int ValueW          = 32;
  localparam int CountOutW       = 5;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    req_type_t                  req_type;
    logic signed [ValueW-1:0]   value;
  } svl_req_t;

  typedef struct packed {
    status_t                    status;
    logic [CountOutW-1:0]       entry_count;
    logic                       list_empty;
  } svl_rsp_t;

  // command from the control path to the entry row
  typedef struct packed {
    logic                       do_insert;
    logic                       do_delete;
    logic signed [ValueW-1:0]   value;
  } svl_row_cmd_t;

endpackage

/* hw/rtl/svl_entry_row.sv */
// ----------------------------------------------------------------------------
// svl_entry_row
// Row of sorted entry registers with a per-entry compare against the request
// value and a one-place shift for insert or delete.
// ----------------------------------------------------------------------------
module svl_entry_row
  import svl_pkg::*;
#(
  parameter int CAPACITY = DefaultCapacity,
  parameter int CntW     = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  svl_row_cmd_t        cmd,
  input  logic [CntW-1:0]     count,
  output logic                found
);

  logic signed [ValueW-1:0] entries [CAPACITY];
  logic signed [ValueW-1:0] ins_next [CAPACITY];
  logic signed [ValueW-1:0] del_next [CAPACITY];
  logic [CAPACITY-1:0]      lt;
  logic [CAPACITY-1:0]      eq;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic valid;

    assign valid = CntW'(i) < count;
    assign lt[i] = valid && (entries[i] < cmd.value);
    assign eq[i] = valid && (entries[i] == cmd.value);

    // insert: keep smaller entries, drop the value at the first slot not
    // below it, move the rest up one place
    if (i == 0) begin : g_first
      assign ins_next[i] = lt[i] ? entries[i] : cmd.value;
    end else begin : g_rest
      assign ins_next[i] = lt[i]     ? entries[i] :
                           lt[i-1]   ? cmd.value  : entries[i-1];
    end

    // delete: everything from the matching slot on moves down one place
    if (i == CAPACITY - 1) begin : g_last
      assign del_next[i] = entries[i];
    end else begin : g_mid
      assign del_next[i] = lt[i] ? entries[i] : entries[i+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.do_insert) begin
        entries[i] <= ins_next[i];
      end else if (cmd.do_delete) begin
        entries[i] <= del_next[i];
      end
    end
  end

  assign found = |eq;

endmodule

/* hw/rtl/sorted_value_list_unit.sv */
// ----------------------------------------------------------------------------
// sorted_value_list_unit
// Bounded list of signed 32-bit values in ascending order with insert,
// delete, lookup and clear requests, one response per request.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   svl_req_t (req_type, value)
//   rsp      out        rsp_valid/rsp_stall   svl_rsp_t (status, entry_count,
//                                             list_empty)
//
// one request per cycle sustained while responses do not stall; a request
// lands in the input register, then executes into the response register
// the per-cycle limit is the parallel compare and one-place shift over the
// entry row, done between the input register and the response register
// reset clears the count and both valid flags; the entry registers are not
// cleared, entries at or above the count are never observed
// a stalled response holds the response register; the input register takes
// a new request while it is empty or while its own request can move on
//
module sorted_value_list_unit
  import svl_pkg::*;
#(
  parameter int CAPACITY = DefaultCapacity
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  svl_req_t  req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output svl_rsp_t  rsp
);

  localparam int CntW = $clog2(CAPACITY + 1);

  // input register
  logic            in_valid;
  svl_req_t        in_req;

  // stored count and execute path
  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic            exec;
  logic            full;
  logic            found;
  status_t         status_next;
  svl_row_cmd_t    row_cmd;
  svl_rsp_t        rsp_next;

  // request executes when the response register is free or draining
  assign exec      = in_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = in_valid && !exec;
  assign full      = (count == CntW'(CAPACITY));

  always_comb begin
    status_next = ST_DONE;
    count_next  = count;
    unique case (in_req.req_type)
      REQ_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CntW'(1);
        end
      end
      REQ_DELETE: begin
        if (found) begin
          count_next = count - CntW'(1);
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      REQ_LOOKUP: begin
        if (!found) begin
          status_next = ST_NOT_FOUND;
        end
      end
      REQ_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  // entry row only changes on an insert with room or a delete that hits
  assign row_cmd.do_insert = exec && (in_req.req_type == REQ_INSERT) && !full;
  assign row_cmd.do_delete = exec && (in_req.req_type == REQ_DELETE) && found;
  assign row_cmd.value     = in_req.value;

  assign rsp_next.status      = status_next;
  assign rsp_next.entry_count = CountOutW'(count_next);
  assign rsp_next.list_empty  = (count_next == '0);

  svl_entry_row #(
    .CAPACITY (CAPACITY),
    .CntW     (CntW)
  ) u_row (
    .clk   (clk),
    .cmd   (row_cmd),
    .count (count),
    .found (found)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      rsp_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (!req_stall) begin
        in_valid <= req_valid;
      end
      if (exec) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      in_req <= req;
    end
    if (exec) begin
      rsp <= rsp_next;
    end
  end

endmodule

/* hw/rtl/svl_checker.sv */
// ----------------------------------------------------------------------------
// svl_checker
// Port-level checks for the sorted value list, bound to the top level.
// ----------------------------------------------------------------------------
module svl_checker
  import svl_pkg::*;
#(
  parameter int CAPACITY = DefaultCapacity
) (
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_stall,
  input svl_req_t  req,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input svl_rsp_t  rsp
);

  localparam logic [CountOutW-1:0] CapCount = CountOutW'(CAPACITY);

  // empty flag agrees with the count
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.list_empty == (rsp.entry_count == '0)))
    else $error("list_empty disagrees with entry_count");

  // a dropped insert only happens at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_FULL) |-> (rsp.entry_count == CapCount))
    else $error("full status below capacity");

  // with no response pending the input side never stalls
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> !req_stall)
    else $error("request stalled with empty response register");

  // no response right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response changed");

endmodule

bind sorted_value_list_unit svl_checker #(.CAPACITY(CAPACITY)) u_svl_checker (.*);
